>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is active
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, quiet while reset is active
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that also checks through reset
`define ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> hdl/ple_pkg.sv
// Package for the positional list engine: request and status codes,
// default sizes, stream widths and the cell control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  // Default sizing
  localparam int CAPACITY_DEF    = 64;
  localparam int ENTRY_WIDTH_DEF = 32;

  // Broadcast position width, enough for the largest supported capacity
  localparam int MAX_IDX_W = 10;

  // Field widths on the streams
  localparam int REQ_W    = 3;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_HEAD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REM_POS  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REM_TAIL = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PAST_END = 2'd3;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic                 ins;   // shift up from pos, load new word at pos
    logic                 rem;   // shift down from pos
    logic [MAX_IDX_W-1:0] pos;
  } ctrl_t;

endpackage

`default_nettype wire

>>> hdl/positional_list_engine.sv
// Top level of the positional list engine: request decode, entry count,
// the chain of ple_cell slots and the result register. Depends on ple_pkg.
// Latency: a result is presented the cycle after its request transfer.
// Throughput: one request per cycle while results are taken; every insert or
// removal shifts the whole cell chain as it is taken. A stalled result holds
// off the input; the next request is taken in the cycle that result transfers.
// Reset: clears the entry count and the result valid; slot words are not reset.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY    = ple_pkg::CAPACITY_DEF,
  parameter int ENTRY_WIDTH = ple_pkg::ENTRY_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // in_tdata: req_type[2:0], position[8:3], entry_value[40:9], zero pad
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [ple_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: removed_value[31:0], status[33:32], entry_count[40:34], zero pad
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [ple_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
  localparam int PADW = ple_pkg::OUT_TDATA_W - ple_pkg::VALUE_W
                        - ple_pkg::STATUS_W - ple_pkg::COUNT_W;

  // Input fields
  logic [ple_pkg::REQ_W-1:0]   req;
  logic [ple_pkg::POS_W-1:0]   pos;
  logic [ple_pkg::VALUE_W-1:0] value;

  assign req   = in_tdata[2:0];
  assign pos   = in_tdata[8:3];
  assign value = in_tdata[40:9];

  logic fire;
  assign in_tready = !out_tvalid || out_tready;
  assign fire      = in_tvalid && in_tready;

  // Entry count
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  // Decode: effective position and status
  logic [CMPW-1:0]               pos_c;
  logic [CMPW-1:0]               cnt_c;
  logic [CMPW-1:0]               eff;
  logic                          is_ins;
  logic                          is_rem;
  logic                          full;
  logic                          empty;
  logic [ple_pkg::STATUS_W-1:0]  status;

  assign pos_c = CMPW'(pos);
  assign cnt_c = CMPW'(cnt_r);
  assign full  = (cnt_r == CW'(CAPACITY));
  assign empty = (cnt_r == '0);

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    eff    = '0;
    case (req)
      ple_pkg::REQ_INS_HEAD: begin
        is_ins = 1'b1;
      end
      ple_pkg::REQ_INS_POS: begin
        is_ins = 1'b1;
        eff    = (pos_c > cnt_c) ? cnt_c : pos_c;
      end
      ple_pkg::REQ_INS_TAIL: begin
        is_ins = 1'b1;
        eff    = cnt_c;
      end
      ple_pkg::REQ_REM_HEAD: begin
        is_rem = 1'b1;
      end
      ple_pkg::REQ_REM_POS: begin
        is_rem = 1'b1;
        eff    = pos_c;
      end
      ple_pkg::REQ_REM_TAIL: begin
        is_rem = 1'b1;
        eff    = cnt_c - CMPW'(1);
      end
      default: begin
        // unused codes leave the list alone
      end
    endcase
  end

  always_comb begin
    status = ple_pkg::ST_OK;
    if (is_ins && full) begin
      status = ple_pkg::ST_FULL;
    end else if (is_rem && empty) begin
      status = ple_pkg::ST_EMPTY;
    end else if (is_rem && (eff >= cnt_c)) begin
      status = ple_pkg::ST_PAST_END;
    end
  end

  // Broadcast control
  ple_pkg::ctrl_t ctrl;
  assign ctrl.ins = fire && is_ins && (status == ple_pkg::ST_OK);
  assign ctrl.rem = fire && is_rem && (status == ple_pkg::ST_OK);
  assign ctrl.pos = ple_pkg::MAX_IDX_W'(eff);

  logic [ENTRY_WIDTH-1:0] new_word;
  assign new_word = ENTRY_WIDTH'(value);

  // Chain of slots
  logic [ENTRY_WIDTH-1:0] slot_w [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_w;
    logic [ENTRY_WIDTH-1:0] right_w;
    if (i == 0) begin : g_head
      assign left_w = new_word;
    end else begin : g_mid_l
      assign left_w = slot_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = slot_w[i];
    end else begin : g_mid_r
      assign right_w = slot_w[i+1];
    end
    ple_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .INDEX       (i)
    ) u_cell (
      .clk          (clk),
      .ctrl_i       (ctrl),
      .new_word_i   (new_word),
      .left_word_i  (left_w),
      .right_word_i (right_w),
      .word_o       (slot_w[i])
    );
  end

  // Pick the word leaving the list (one-hot AND-OR over the slots)
  logic [ENTRY_WIDTH-1:0] sel_word;
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ple_pkg::MAX_IDX_W'(i) == ctrl.pos) begin
        sel_word = sel_word | slot_w[i];
      end
    end
  end

  logic [ple_pkg::VALUE_W-1:0] removed;
  assign removed = (is_rem && (status == ple_pkg::ST_OK)) ?
                   ple_pkg::VALUE_W'(sel_word) : '0;

  // Count update
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (ctrl.rem) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result register
  logic                             out_valid_r;
  logic [ple_pkg::OUT_TDATA_W-1:0]  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {PADW'(0), ple_pkg::COUNT_W'(cnt_nxt), status, removed};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> hdl/ple_cell.sv
// One slot of the shifting list: holds a single entry word and takes its
// neighbor's or the new word on insert or removal. Depends on ple_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ple_cell #(
  parameter int ENTRY_WIDTH = ple_pkg::ENTRY_WIDTH_DEF,
  parameter int INDEX       = 0
) (
  input  wire                    clk,
  input  wire ple_pkg::ctrl_t    ctrl_i,
  input  wire [ENTRY_WIDTH-1:0]  new_word_i,
  input  wire [ENTRY_WIDTH-1:0]  left_word_i,   // from slot INDEX-1
  input  wire [ENTRY_WIDTH-1:0]  right_word_i,  // from slot INDEX+1
  output logic [ENTRY_WIDTH-1:0] word_o
);

  localparam logic [ple_pkg::MAX_IDX_W-1:0] MY_IDX = ple_pkg::MAX_IDX_W'(INDEX);

  logic [ENTRY_WIDTH-1:0] word_r;
  logic [ENTRY_WIDTH-1:0] word_nxt;

  // Next word: open a gap on insert, close it on removal
  always_comb begin
    word_nxt = word_r;
    if (ctrl_i.ins) begin
      if (MY_IDX > ctrl_i.pos) begin
        word_nxt = left_word_i;
      end else if (MY_IDX == ctrl_i.pos) begin
        word_nxt = new_word_i;
      end
    end else if (ctrl_i.rem) begin
      if (MY_IDX >= ctrl_i.pos) begin
        word_nxt = right_word_i;
      end
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;

endmodule

`default_nettype wire

>>> hdl/ple_checker.sv
// Port-level checker for positional_list_engine, bound to the top level.
// Depends on ple_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ple_checker #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [ple_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [ple_pkg::STATUS_W-1:0] st;
  logic [ple_pkg::COUNT_W-1:0]  cnt;
  logic [ple_pkg::VALUE_W-1:0]  rmv;

  assign rmv = out_tdata[31:0];
  assign st  = out_tdata[33:32];
  assign cnt = out_tdata[40:34];

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Full rejection only happens at capacity
  `ASSERT_IMPLY(a_full_cnt, clk, rst_n, out_tvalid && (st == ple_pkg::ST_FULL), cnt == ple_pkg::COUNT_W'(CAPACITY))

  // Empty rejection: nothing held and nothing returned
  `ASSERT_IMPLY(a_empty_cnt, clk, rst_n, out_tvalid && (st == ple_pkg::ST_EMPTY), (cnt == '0) && (rmv == '0))

  // Out-of-range removal returns no word
  `ASSERT_IMPLY(a_past_end, clk, rst_n, out_tvalid && (st == ple_pkg::ST_PAST_END), rmv == '0)

  // No result right after reset
  `ASSERT_NEXT_ALWAYS(a_rst_idle, clk, !rst_n, !out_tvalid)

endmodule

bind positional_list_engine ple_checker #(
  .CAPACITY (CAPACITY)
) u_ple_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> test/testbench.sv
// Self-checking bench for positional_list_engine: a directed table followed by random
// insert/remove traffic with random stalls, checked against a shadow list. Depends on ple_pkg.
`timescale 1ns / 1ps

module testbench;
  import ple_pkg::*;

  // Unused request codes, ignored by the block
  localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

  localparam int LIST_DEPTH      = CAPACITY_DEF;
  localparam int RANDOM_REQUESTS = 750;
  localparam int PRESSURE_AFTER  = 300;
  localparam int PRESSURE_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 4;
  localparam int N_DIR           = 22;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] word;
  } list_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  removed;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } list_resp_t;

  typedef struct packed {
    list_req_t  req;
    logic       typed;   // want holds a literal expectation
    list_resp_t want;
  } directed_row_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [VALUE_W-1:0] shadow_list[$];
  list_resp_t         pending_results[$];
  int                 requests_sent = 0;
  int                 mismatch_count = 0;
  bit                 no_idle = 1'b0;

  positional_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Directed table: empty-list removals, unused codes, extremes, append past end
  directed_row_t dir_rows [N_DIR] = '{
    '{'{REQ_REM_HEAD, 6'd0,  32'h0},        1'b1, '{32'h0, ST_EMPTY,    7'd0}},
    '{'{REQ_REM_POS,  6'd63, 32'h0},        1'b1, '{32'h0, ST_EMPTY,    7'd0}},
    '{'{REQ_REM_TAIL, 6'd0,  32'hFFFFFFFF}, 1'b1, '{32'h0, ST_EMPTY,    7'd0}},
    '{'{REQ_UNUSED_6, 6'd63, 32'hFFFFFFFF}, 1'b1, '{32'h0, ST_OK,       7'd0}},
    '{'{REQ_INS_HEAD, 6'd0,  32'hFFFFFFFF}, 1'b1, '{32'h0, ST_OK,       7'd1}},
    '{'{REQ_INS_POS,  6'd63, 32'h0},        1'b1, '{32'h0, ST_OK,       7'd2}},
    '{'{REQ_INS_TAIL, 6'd0,  32'hA5A5A5A5}, 1'b1, '{32'h0, ST_OK,       7'd3}},
    '{'{REQ_INS_POS,  6'd0,  32'h5A5A5A5A}, 1'b0, '0},
    '{'{REQ_INS_POS,  6'd2,  32'h12345678}, 1'b0, '0},
    '{'{REQ_REM_POS,  6'd63, 32'hFFFFFFFF}, 1'b1, '{32'h0, ST_PAST_END, 7'd5}},
    '{'{REQ_REM_POS,  6'd5,  32'h0},        1'b1, '{32'h0, ST_PAST_END, 7'd5}},
    '{'{REQ_UNUSED_7, 6'd0,  32'h0},        1'b1, '{32'h0, ST_OK,       7'd5}},
    '{'{REQ_REM_POS,  6'd4,  32'h0},        1'b0, '0},
    '{'{REQ_REM_HEAD, 6'd0,  32'h0},        1'b0, '0},
    '{'{REQ_REM_TAIL, 6'd0,  32'h0},        1'b0, '0},
    '{'{REQ_REM_POS,  6'd1,  32'h0},        1'b0, '0},
    '{'{REQ_REM_HEAD, 6'd0,  32'h0},        1'b0, '0},
    '{'{REQ_REM_TAIL, 6'd0,  32'h0},        1'b1, '{32'h0, ST_EMPTY,    7'd0}},
    '{'{REQ_INS_TAIL, 6'd0,  32'h0},        1'b0, '0},
    '{'{REQ_INS_HEAD, 6'd0,  32'h80000001}, 1'b0, '0},
    '{'{REQ_REM_POS,  6'd1,  32'h0},        1'b0, '0},
    '{'{REQ_REM_POS,  6'd0,  32'h0},        1'b0, '0}
  };

  // Shadow list: apply one request and return the result it produces
  function automatic list_resp_t predict_outcome(list_req_t r);
    list_resp_t  res;
    int unsigned at;
    res = '0;
    res.status = ST_OK;
    case (r.kind)
      REQ_INS_HEAD, REQ_INS_POS, REQ_INS_TAIL: begin
        if (shadow_list.size() >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (r.kind == REQ_INS_HEAD) at = 0;
          else if (r.kind == REQ_INS_TAIL) at = shadow_list.size();
          else at = r.pos;
          // past the end appends at the tail
          if (at > shadow_list.size()) at = shadow_list.size();
          shadow_list.insert(at, r.word);
        end
      end
      REQ_REM_HEAD, REQ_REM_POS, REQ_REM_TAIL: begin
        if (shadow_list.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (r.kind == REQ_REM_HEAD) at = 0;
          else if (r.kind == REQ_REM_TAIL) at = shadow_list.size() - 1;
          else at = r.pos;
          if (at >= shadow_list.size()) begin
            res.status = ST_PAST_END;
          end else begin
            res.removed = shadow_list[at];
            shadow_list.delete(at);
          end
        end
      end
      default: ;
    endcase
    res.count = COUNT_W'(shadow_list.size());
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic list_req_t random_request(traffic_mix_t mix);
    list_req_t   r;
    int unsigned ins_pct;
    int unsigned len;
    len = shadow_list.size();
    ins_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
    if ($urandom_range(0, 99) < 3) begin
      r.kind = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
    end else if ($urandom_range(0, 99) < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       r.kind = REQ_INS_HEAD;
        1:       r.kind = REQ_INS_POS;
        default: r.kind = REQ_INS_TAIL;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       r.kind = REQ_REM_HEAD;
        1:       r.kind = REQ_REM_POS;
        default: r.kind = REQ_REM_TAIL;
      endcase
    end
    // mostly positions up to the current length, the rest anywhere
    if ($urandom_range(0, 9) < 7)
      r.pos = POS_W'((len > 63) ? 63 : $urandom_range(0, len));
    else
      r.pos = POS_W'($urandom_range(0, 63));
    r.word = $urandom;
    return r;
  endfunction

  // Offer one request; called just after a rising edge, returns just after its transfer
  task automatic send_request(input list_req_t r, input logic typed, input list_resp_t want);
    int         gap;
    list_resp_t got;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, r.word, r.pos, r.kind};
    do @(negedge clk); while (!in_tready);
    got = predict_outcome(r);
    pending_results.push_back(typed ? want : got);
    requests_sent++;
    @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off to back up the block
  initial begin
    int  stall_left;
    bit  pressure_done;
    stall_left = 0;
    pressure_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!pressure_done && requests_sent >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        out_tready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(negedge clk) begin
    list_resp_t exp_r;
    list_resp_t act_r;
    if (rst_n && out_tvalid && out_tready) begin
      act_r.removed = out_tdata[31:0];
      act_r.status  = out_tdata[33:32];
      act_r.count   = out_tdata[40:34];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result removed=%h status=%0d count=%0d",
                 $time, act_r.removed, act_r.status, act_r.count);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (act_r.removed !== exp_r.removed) begin
          $display("%0t: removed_value expected %h actual %h", $time, exp_r.removed,
                   act_r.removed);
          mismatch_count++;
        end
        if (act_r.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, act_r.status);
          mismatch_count++;
        end
        if (act_r.count !== exp_r.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, exp_r.count,
                   act_r.count);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int           done;
    int           seg_len;
    traffic_mix_t mix;
    bit           first_seg;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_DIR; k++)
      send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

    // Random traffic in segments that fill, drain or mix the list
    done = 0;
    first_seg = 1'b1;
    while (done < RANDOM_REQUESTS) begin
      mix = first_seg ? MIX_FILL : traffic_mix_t'($urandom_range(0, 2));
      first_seg = 1'b0;
      seg_len = (mix == MIX_BALANCED) ? $urandom_range(20, 60) : $urandom_range(40, 90);
      no_idle = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < seg_len && done < RANDOM_REQUESTS; i++) begin
        send_request(random_request(mix), 1'b0, '0);
        done++;
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
